// ===== hw/rtl/wbts_pkg.sv =====
// ----------------------------------------------------------------------------
// wbts_pkg
// Shared types and constants of the wrapped bilinear texture sampler.
// ----------------------------------------------------------------------------
package wbts_pkg;

  localparam int MAX_DIM    = 64;
  localparam int FRAC_BITS  = 16;
  localparam int DIM_BITS   = $clog2(MAX_DIM) + 1;
  localparam int POS_BITS   = $clog2(MAX_DIM);
  localparam int ADDR_BITS  = 2 * POS_BITS;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int SCALE_BITS = FRAC_BITS + DIM_BITS;
  localparam int WGT_BITS   = FRAC_BITS + 1;
  localparam int LERP_BITS  = 8 + FRAC_BITS;
  localparam int BLEND_BITS = 8 + 2 * FRAC_BITS;

  typedef enum logic [1:0] {
    MODE_NEAREST = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_SMOOTH  = 2'd2,
    MODE_OFF     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2,
    REG_SPARE  = 2'd3
  } reg_index_t;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [11:0]        texel_index;
    logic [31:0]        texel_rgba;
    logic signed [23:0] coord_u;
    logic signed [23:0] coord_v;
  } item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } result_t;

endpackage

// ===== hw/rtl/wrapped_bilinear_texture_sampler.sv =====
// ----------------------------------------------------------------------------
// wrapped_bilinear_texture_sampler
// A sample result strobes after the start beat has passed through stages 0 to 5 in order.
// Throughput: one beat per cycle; busy stays low, four texel memory copies
// serve the four corner reads of every sample in the same cycle.
// Reset: clears pipeline valids and restores width 64, height 64, smoothstep;
// texel contents are undefined until loaded. Results cannot be stalled.
// ----------------------------------------------------------------------------
module wrapped_bilinear_texture_sampler
  import wbts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [DIM_BITS-1:0] image_width, image_height;
  logic [1:0]          filter_mode;
  logic [DIM_BITS-1:0] w_eff, h_eff;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_BITS'(MAX_DIM);
      image_height <= DIM_BITS'(MAX_DIM);
      filter_mode  <= MODE_SMOOTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_BITS-1:0];
        REG_MODE:   filter_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = image_width;
    if (image_width == '0) w_eff = DIM_BITS'(1);
    else if (image_width > DIM_BITS'(MAX_DIM)) w_eff = DIM_BITS'(MAX_DIM);
    h_eff = image_height;
    if (image_height == '0) h_eff = DIM_BITS'(1);
    else if (image_height > DIM_BITS'(MAX_DIM)) h_eff = DIM_BITS'(MAX_DIM);
  end

  // stage 0: input capture
  logic  p0_valid;
  item_t p0_item;

  always_ff @(posedge clk) begin
    if (rst) p0_valid <= 1'b0;
    else     p0_valid <= start && !busy;
    p0_item <= item;
  end

  // stage 1: scale wrapped fractions
  logic                  p1_valid, p1_kind;
  logic [ADDR_BITS-1:0]  p1_idx;
  logic [31:0]           p1_rgba;
  logic [SCALE_BITS-1:0] p1_su, p1_sv;

  always_ff @(posedge clk) begin
    if (rst) p1_valid <= 1'b0;
    else     p1_valid <= p0_valid;
    p1_kind <= p0_item.kind;
    p1_idx  <= p0_item.texel_index[ADDR_BITS-1:0];
    p1_rgba <= p0_item.texel_rgba;
    p1_su   <= SCALE_BITS'(p0_item.coord_u[FRAC_BITS-1:0]) * SCALE_BITS'(w_eff);
    p1_sv   <= SCALE_BITS'(p0_item.coord_v[FRAC_BITS-1:0]) * SCALE_BITS'(h_eff);
  end

  // stage 2: corner addresses, squared weights
  logic [POS_BITS-1:0]  x0, y0, x1, y1;
  logic [DIM_BITS-1:0]  x0n, y0n;
  logic [FRAC_BITS-1:0] wx, wy;
  logic                 p2_valid, p2_kind;
  logic [ADDR_BITS-1:0] p2_idx;
  logic [31:0]          p2_rgba;
  logic [ADDR_BITS-1:0] p2_a00, p2_a10, p2_a01, p2_a11;
  logic [FRAC_BITS-1:0] p2_wx, p2_wy, p2_wx2, p2_wy2;
  logic [2*FRAC_BITS-1:0] wx_sq, wy_sq;

  always_comb begin
    x0    = p1_su[FRAC_BITS +: POS_BITS];
    y0    = p1_sv[FRAC_BITS +: POS_BITS];
    x0n   = DIM_BITS'(x0) + DIM_BITS'(1);
    y0n   = DIM_BITS'(y0) + DIM_BITS'(1);
    x1    = (x0n >= w_eff) ? '0 : x0n[POS_BITS-1:0];
    y1    = (y0n >= h_eff) ? '0 : y0n[POS_BITS-1:0];
    wx    = p1_su[FRAC_BITS-1:0];
    wy    = p1_sv[FRAC_BITS-1:0];
    wx_sq = (2*FRAC_BITS)'(wx) * (2*FRAC_BITS)'(wx);
    wy_sq = (2*FRAC_BITS)'(wy) * (2*FRAC_BITS)'(wy);
  end

  always_ff @(posedge clk) begin
    if (rst) p2_valid <= 1'b0;
    else     p2_valid <= p1_valid;
    p2_kind <= p1_kind;
    p2_idx  <= p1_idx;
    p2_rgba <= p1_rgba;
    p2_a00  <= ADDR_BITS'(ADDR_BITS'(y0) * ADDR_BITS'(w_eff) + ADDR_BITS'(x0));
    p2_a10  <= ADDR_BITS'(ADDR_BITS'(y0) * ADDR_BITS'(w_eff) + ADDR_BITS'(x1));
    p2_a01  <= ADDR_BITS'(ADDR_BITS'(y1) * ADDR_BITS'(w_eff) + ADDR_BITS'(x0));
    p2_a11  <= ADDR_BITS'(ADDR_BITS'(y1) * ADDR_BITS'(w_eff) + ADDR_BITS'(x1));
    p2_wx   <= wx;
    p2_wy   <= wy;
    p2_wx2  <= wx_sq[FRAC_BITS +: FRAC_BITS];
    p2_wy2  <= wy_sq[FRAC_BITS +: FRAC_BITS];
  end

  // stage 3: texel reads, loads written, smoothstep finish
  logic [31:0] t00, t10, t01, t11;
  logic        load_we;

  assign load_we = p2_valid && (p2_kind == KIND_LOAD);

  wbts_texram u_ram00 (.clk, .we(load_we), .waddr(p2_idx), .wdata(p2_rgba),
                       .raddr(p2_a00), .rdata(t00));
  wbts_texram u_ram10 (.clk, .we(load_we), .waddr(p2_idx), .wdata(p2_rgba),
                       .raddr(p2_a10), .rdata(t10));
  wbts_texram u_ram01 (.clk, .we(load_we), .waddr(p2_idx), .wdata(p2_rgba),
                       .raddr(p2_a01), .rdata(t01));
  wbts_texram u_ram11 (.clk, .we(load_we), .waddr(p2_idx), .wdata(p2_rgba),
                       .raddr(p2_a11), .rdata(t11));

  localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS+2)'(3 * (1 << FRAC_BITS));

  logic [2*FRAC_BITS+1:0] sx_prod, sy_prod;
  logic                   p3_valid;
  logic [FRAC_BITS-1:0]   p3_wx, p3_wy;

  always_comb begin
    sx_prod = (2*FRAC_BITS+2)'(p2_wx2)
            * (2*FRAC_BITS+2)'(THREE_ONE - {1'b0, p2_wx, 1'b0});
    sy_prod = (2*FRAC_BITS+2)'(p2_wy2)
            * (2*FRAC_BITS+2)'(THREE_ONE - {1'b0, p2_wy, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) p3_valid <= 1'b0;
    else     p3_valid <= p2_valid && (p2_kind == KIND_SAMPLE);
    if (filter_mode == MODE_SMOOTH) begin
      p3_wx <= sx_prod[FRAC_BITS +: FRAC_BITS];
      p3_wy <= sy_prod[FRAC_BITS +: FRAC_BITS];
    end else begin
      p3_wx <= p2_wx;
      p3_wy <= p2_wy;
    end
  end

  // stage 4: blend along y at both columns
  logic [WGT_BITS-1:0]  wy_hi, wy_lo;
  logic [LERP_BITS-1:0] lerp_a [4];
  logic [LERP_BITS-1:0] lerp_b [4];
  logic [LERP_BITS-1:0] p4_a [4];
  logic [LERP_BITS-1:0] p4_b [4];
  logic                 p4_valid;
  logic [FRAC_BITS-1:0] p4_wx;
  logic [31:0]          p4_near;

  always_comb begin
    wy_lo = WGT_BITS'(p3_wy);
    wy_hi = WGT_BITS'(1 << FRAC_BITS) - wy_lo;
    for (int c = 0; c < 4; c++) begin
      lerp_a[c] = LERP_BITS'(LERP_BITS'(t00[8*c +: 8]) * LERP_BITS'(wy_hi)
                + LERP_BITS'(t01[8*c +: 8]) * LERP_BITS'(wy_lo));
      lerp_b[c] = LERP_BITS'(LERP_BITS'(t10[8*c +: 8]) * LERP_BITS'(wy_hi)
                + LERP_BITS'(t11[8*c +: 8]) * LERP_BITS'(wy_lo));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p4_valid <= 1'b0;
    else     p4_valid <= p3_valid;
    p4_wx   <= p3_wx;
    p4_near <= t00;
    for (int c = 0; c < 4; c++) begin
      p4_a[c] <= lerp_a[c];
      p4_b[c] <= lerp_b[c];
    end
  end

  // stage 5: blend along x, format select
  logic [WGT_BITS-1:0]   wx_hi, wx_lo;
  logic [BLEND_BITS-1:0] blend [4];
  logic [15:0]           chan_out [4];

  always_comb begin
    wx_lo = WGT_BITS'(p4_wx);
    wx_hi = WGT_BITS'(1 << FRAC_BITS) - wx_lo;
    for (int c = 0; c < 4; c++) begin
      blend[c] = BLEND_BITS'(BLEND_BITS'(p4_a[c]) * BLEND_BITS'(wx_hi)
               + BLEND_BITS'(p4_b[c]) * BLEND_BITS'(wx_lo));
      case (filter_mode)
        MODE_NEAREST: chan_out[c] = {p4_near[8*c +: 8], 8'h00};
        MODE_LINEAR,
        MODE_SMOOTH:  chan_out[c] = blend[c][BLEND_BITS-1 -: 16];
        default:      chan_out[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= p4_valid;
    result.red_out   <= chan_out[0];
    result.green_out <= chan_out[1];
    result.blue_out  <= chan_out[2];
    result.alpha_out <= chan_out[3];
  end

endmodule

// ===== hw/rtl/wbts_texram.sv =====
// ----------------------------------------------------------------------------
// wbts_texram
// Texel memory copy: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wbts_texram
  import wbts_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [31:0]          wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [31:0]          rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Regression for the wrapped bilinear texture sampler: fills the low part of the texel store,
// then runs directed and random sample and load beats under several size and
// filter settings, checking every result against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench
  import wbts_pkg::*;
();

  class texel_scoreboard;
    logic [31:0]     texels [DEPTH];
    int unsigned     width_reg;
    int unsigned     height_reg;
    int unsigned     mode_reg;
    result_t         pending [$];
    int              errors;

    function void reset_state();
      width_reg  = 64;
      height_reg = 64;
      mode_reg   = MODE_SMOOTH;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] data);
      case (idx)
        REG_WIDTH:  width_reg  = data;
        REG_HEIGHT: height_reg = data;
        REG_MODE:   mode_reg   = data[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(int unsigned s);
      if (s == 0) return 1;
      if (s > MAX_DIM) return MAX_DIM;
      return s;
    endfunction

    function longint unsigned smooth_weight(longint unsigned w);
      longint unsigned w2;
      w2 = (w * w) >> FRAC_BITS;
      return (w2 * (3 * 65536 - 2 * w)) >> FRAC_BITS;
    endfunction

    function void note_item(item_t it);
      int unsigned w, h, x0, y0, x1, y1;
      longint unsigned su, sv, wx, wy, a, b, r, c00, c10, c01, c11;
      logic [31:0] t00, t10, t01, t11;
      logic [15:0] ch [4];
      result_t res;
      if (it.kind == KIND_LOAD) begin
        texels[it.texel_index] = it.texel_rgba;
        return;
      end
      w  = clamp_size(width_reg);
      h  = clamp_size(height_reg);
      su = longint'(it.coord_u[15:0]) * w;
      sv = longint'(it.coord_v[15:0]) * h;
      x0 = su >> FRAC_BITS;
      y0 = sv >> FRAC_BITS;
      if (x0 >= w) x0 = w - 1;
      if (y0 >= h) y0 = h - 1;
      wx = su & 16'hFFFF;
      wy = sv & 16'hFFFF;
      x1 = (x0 + 1 >= w) ? 0 : x0 + 1;
      y1 = (y0 + 1 >= h) ? 0 : y0 + 1;
      if (mode_reg == MODE_SMOOTH) begin
        wx = smooth_weight(wx);
        wy = smooth_weight(wy);
      end
      t00 = texels[y0 * w + x0];
      t10 = texels[y0 * w + x1];
      t01 = texels[y1 * w + x0];
      t11 = texels[y1 * w + x1];
      for (int c = 0; c < 4; c++) begin
        c00 = t00[8*c +: 8];
        c10 = t10[8*c +: 8];
        c01 = t01[8*c +: 8];
        c11 = t11[8*c +: 8];
        if (mode_reg == MODE_NEAREST) begin
          ch[c] = c00 << 8;
        end else if (mode_reg > MODE_SMOOTH) begin
          ch[c] = 0;
        end else begin
          a = c00 * (65536 - wy) + c01 * wy;
          b = c10 * (65536 - wy) + c11 * wy;
          r = a * (65536 - wx) + b * wx;
          ch[c] = r >> (2 * FRAC_BITS - 8);
        end
      end
      res.red_out   = ch[0];
      res.green_out = ch[1];
      res.blue_out  = ch[2];
      res.alpha_out = ch[3];
      pending.push_back(res);
    endfunction

    function void compare_channel(string name, logic [15:0] e, logic [15:0] act);
      if (e !== act) begin
        $display("%0t: %s mismatch expected %h actual %h", $time, name, e, act);
        errors++;
      end
    endfunction

    function void check_result(result_t act);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_channel("red", e.red_out, act.red_out);
      compare_channel("green", e.green_out, act.green_out);
      compare_channel("blue", e.blue_out, act.blue_out);
      compare_channel("alpha", e.alpha_out, act.alpha_out);
    endfunction
  endclass

  localparam int FILL_DEPTH = 1024;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  texel_scoreboard sb = new();
  int unsigned     cycle_count;
  int unsigned     idle_pct;

  wrapped_bilinear_texture_sampler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("wrapped_bilinear_texture_sampler regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  task automatic send_item(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    item  = it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    @(negedge clk);
    start     = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start     = 1'b0;
    cfg_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.kind        = ($urandom_range(99) < 80) ? KIND_SAMPLE : KIND_LOAD;
    it.texel_index = 12'($urandom);
    it.texel_rgba  = $urandom;
    it.coord_u     = 24'($urandom);
    it.coord_v     = 24'($urandom);
    case ($urandom_range(7))
      0: it.coord_u[15:0] = 16'hFFFF;
      1: it.coord_v[15:0] = 16'h0000;
      2: it.coord_u[15:0] = 16'h0000;
      3: it.coord_v[15:0] = 16'hFFFF;
      default: ;
    endcase
    return it;
  endfunction

  function automatic item_t sample_at(logic [23:0] u, logic [23:0] v);
    item_t it;
    it.kind        = KIND_SAMPLE;
    it.texel_index = 12'($urandom);
    it.texel_rgba  = $urandom;
    it.coord_u     = u;
    it.coord_v     = v;
    return it;
  endfunction

  // every size pair below stays inside the filled part of the store
  logic [6:0] widths  [12] = '{127, 1, 0, 9, 64, 3, 7, 33, 16, 2, 5, 32};
  logic [6:0] heights [12] = '{16, 1, 0, 100, 1, 5, 64, 17, 64, 2, 9, 32};
  logic [1:0] modes   [12] = '{MODE_SMOOTH, MODE_LINEAR, MODE_NEAREST, MODE_SMOOTH,
                               MODE_LINEAR, MODE_OFF, MODE_SMOOTH, MODE_LINEAR,
                               MODE_NEAREST, MODE_SMOOTH, MODE_LINEAR, MODE_SMOOTH};
  logic [23:0] corners [8] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                               24'h00FFFF, 24'h008000, 24'h010000, 24'hFF0001};

  initial begin
    item_t it;
    sb.reset_state();
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_WIDTH;
    cfg_data    = '0;
    cycle_count = 0;
    idle_pct    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the low part of the store so no sample reads an unwritten texel
    for (int i = 0; i < FILL_DEPTH; i++) begin
      it            = '0;
      it.kind       = KIND_LOAD;
      it.texel_index = 12'(i);
      it.texel_rgba = (i < 4) ? ((i == 0) ? 32'h0 : (i == 1) ? 32'hFFFFFFFF :
                      (i == 2) ? 32'hFF00FF00 : 32'h00FF00FF) : $urandom;
      send_item(it);
    end
    // reset settings first, rows kept inside the filled part
    for (int k = 0; k < 8; k++) begin
      send_item(sample_at(corners[k], {8'($urandom), 16'($urandom_range(16'h3BFF))}));
    end
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 11;
        default: idle_pct = 49;
      endcase
      write_reg(REG_WIDTH, widths[ph]);
      write_reg(REG_HEIGHT, heights[ph]);
      write_reg(REG_MODE, {5'($urandom), modes[ph]});
      if (ph == 4) write_reg(REG_SPARE, 7'($urandom));
      for (int k = 0; k < 8; k++) send_item(sample_at(corners[k], corners[(k + 3) % 8]));
      for (int n = 0; n < 56; n++) send_item(rand_item());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("wrapped_bilinear_texture_sampler regression: pass");
    end else begin
      $display("wrapped_bilinear_texture_sampler regression: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/wbts_pkg.sv
hw/rtl/wbts_texram.sv
hw/rtl/wrapped_bilinear_texture_sampler.sv
sim/testbench.sv
